@@ hdl/ttlc_pkg.sv @@
package ttlc_pkg;

	localparam int ENTRIES = 1024;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W = 64;
	localparam int TYPE_W = 16;
	localparam int ADDR_W = 64;
	localparam int TTL_W = 32;
	localparam int TIME_W = 64;
	localparam int MS_PER_SEC = 1000;
	localparam int MS_W = TTL_W + $clog2(MS_PER_SEC);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_STORE  = 2'd1,
		OP_SWEEP  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [KEY_W-1:0]  lookup_key;
		logic [TYPE_W-1:0] rec_type;
		logic [ADDR_W-1:0] addr_hi;
		logic [ADDR_W-1:0] addr_lo;
		logic [TTL_W-1:0]  ttl_sec;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              expired_removed;
		logic [ADDR_W-1:0] out_addr_hi;
		logic [ADDR_W-1:0] out_addr_lo;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TYPE_W-1:0] rtype;
		logic [ADDR_W-1:0] addr_hi;
		logic [ADDR_W-1:0] addr_lo;
		logic [TIME_W-1:0] expiry;
	} rec_t;

	typedef struct packed {
		logic en;
		logic vld;
		logic match;
	} scan_t;

	typedef struct packed {
		logic             match_have;
		logic [IDX_W-1:0] target;
	} pick_t;

endpackage

@@ hdl/ttlc_pick.sv @@
module ttlc_pick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  ttlc_pkg::scan_t            scan,
	input  logic [ttlc_pkg::IDX_W-1:0] idx,
	input  logic [ttlc_pkg::TIME_W-1:0] expiry,
	output ttlc_pkg::pick_t            pick
);
	import ttlc_pkg::*;

	logic             match_have_q;
	logic             free_have_q;
	logic             min_have_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] min_idx_q;
	logic [TIME_W-1:0] min_exp_q;
	logic             take_match;
	logic             take_free;
	logic             take_min;

	assign take_match = scan.en && scan.match && !match_have_q;
	assign take_free = scan.en && !scan.vld && !free_have_q;
	assign take_min = scan.en && scan.vld && (!min_have_q || expiry < min_exp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_have_q <= 1'b0;
			free_have_q <= 1'b0;
			min_have_q <= 1'b0;
		end else if (start) begin
			match_have_q <= 1'b0;
			free_have_q <= 1'b0;
			min_have_q <= 1'b0;
		end else begin
			if (take_match) match_have_q <= 1'b1;
			if (take_free) free_have_q <= 1'b1;
			if (take_min) min_have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) match_idx_q <= idx;
		if (take_free) free_idx_q <= idx;
		if (take_min) begin
			min_idx_q <= idx;
			min_exp_q <= expiry;
		end
	end

	always_comb begin
		pick.match_have = match_have_q;
		if (match_have_q) pick.target = match_idx_q;
		else if (free_have_q) pick.target = free_idx_q;
		else pick.target = min_idx_q;
	end

endmodule

@@ hdl/ttl_record_cache.sv @@
// Record cache of ENTRIES address records with millisecond expiry, held in two
// memories with registered reads (records and valid flags). Every item, whatever its
// operation, makes one pass over the table through the single read port, and a new
// item is taken only after the previous one has produced its result; lookups, stores
// and sweeps all cost the same. After reset the valid memory is cleared one entry per
// cycle, so req_ready stays low until every entry is cleared. A finished result sits
// in an output register, and the next item is taken while it waits; that item's result
// then holds the block until the waiting one is taken.
module ttl_record_cache (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ttlc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ttlc_pkg::rsp_t rsp
);
	import ttlc_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_ACT   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  cnt_q;
	req_t              req_q;
	logic [MS_W-1:0]   ttl_ms_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	rec_t              rec_s1;
	logic              vld_s1;
	logic              hit_q;
	logic              exp_q;
	logic [ADDR_W-1:0] addr_hi_q;
	logic [ADDR_W-1:0] addr_lo_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	rec_t              rec_mem [ENTRIES];
	logic              vld_mem [ENTRIES];

	logic              start;
	logic              rd_en;
	logic              match_s1;
	logic              expired_s1;
	logic              first_s1;
	logic              clr_s1;
	logic              store_ok;
	logic              rsp_free;
	logic              vld_we;
	logic [IDX_W-1:0]  vld_wa;
	logic              vld_wd;
	logic              rec_we;
	rec_t              rec_wd;
	scan_t             scan;
	pick_t             pick;

	assign req_ready = (state_q == ST_IDLE);
	assign start = req_valid && req_ready;
	assign rd_en = (state_q == ST_SCAN);
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign match_s1 = vld_s1 && rec_s1.key == req_q.lookup_key && rec_s1.rtype == req_q.rec_type;
	assign expired_s1 = vld_s1 && (req_q.now_ms >= rec_s1.expiry);
	assign first_s1 = v_s1 && match_s1 && !pick.match_have;
	assign clr_s1 = v_s1 && expired_s1 &&
		((req_q.req_type == OP_LOOKUP && first_s1) || req_q.req_type == OP_SWEEP);
	assign store_ok = req_q.req_type == OP_STORE && req_q.ttl_sec != '0 && req_q.lookup_key != '0;

	assign scan.en = v_s1;
	assign scan.vld = vld_s1;
	assign scan.match = match_s1;

	ttlc_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.scan   (scan),
		.idx    (idx_s1),
		.expiry (rec_s1.expiry),
		.pick   (pick)
	);

	always_comb begin
		vld_we = 1'b0;
		vld_wa = cnt_q;
		vld_wd = 1'b0;
		rec_we = 1'b0;
		rec_wd.key = req_q.lookup_key;
		rec_wd.rtype = req_q.rec_type;
		rec_wd.addr_hi = req_q.addr_hi;
		rec_wd.addr_lo = req_q.addr_lo;
		rec_wd.expiry = req_q.now_ms + TIME_W'(ttl_ms_q);
		case (state_q)
			ST_CLEAR: begin
				vld_we = 1'b1;
			end
			ST_SCAN, ST_DRAIN: begin
				vld_we = clr_s1;
				vld_wa = idx_s1;
			end
			ST_ACT: begin
				vld_we = store_ok;
				vld_wa = pick.target;
				vld_wd = 1'b1;
				rec_we = store_ok;
			end
			default: begin
				vld_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rec_s1 <= rec_mem[cnt_q];
			vld_s1 <= vld_mem[cnt_q];
			idx_s1 <= cnt_q;
		end
		if (vld_we) vld_mem[vld_wa] <= vld_wd;
		if (rec_we) rec_mem[pick.target] <= rec_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			hit_q <= 1'b0;
			exp_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_DONE && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (first_s1 && req_q.req_type == OP_LOOKUP) begin
				hit_q <= !expired_s1;
				exp_q <= expired_s1;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						hit_q <= 1'b0;
						exp_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
			ttl_ms_q <= MS_W'(req.ttl_sec) * MS_W'(MS_PER_SEC);
		end
		if (first_s1) begin
			addr_hi_q <= rec_s1.addr_hi;
			addr_lo_q <= rec_s1.addr_lo;
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.hit <= hit_q;
			rsp_q.expired_removed <= exp_q;
			rsp_q.out_addr_hi <= hit_q ? addr_hi_q : '0;
			rsp_q.out_addr_lo <= hit_q ? addr_lo_q : '0;
		end
	end

endmodule

@@ hdl/ttlc_check.sv @@
module ttlc_check (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input ttlc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ttlc_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while another is in work");

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.expired_removed))
		else $error("hit and expired removal together");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.out_addr_hi == '0 && rsp.out_addr_lo == '0)
		else $error("address on a miss");

endmodule

bind ttl_record_cache ttlc_check u_ttlc_check (.*);

@@ bench/tb_ttl_record_cache.sv @@
`timescale 1ns / 1ps

module tb_ttl_record_cache;
	import ttlc_pkg::*;

	localparam logic [TIME_W-1:0] MSEC_PER_SEC = 64'd1000;
	localparam int PHASE_LEN = 48;
	localparam int HOLDOFF_AT = 200;
	localparam int HOLDOFF_CYCLES = 4000;
	localparam int PAUSE_AT = 520;

	typedef enum {MIX_FILL, MIX_EVICT, MIX_FREE} step_mix_t;

	class cache_mirror_t;
		bit                used [ENTRIES];
		bit [KEY_W-1:0]    key_of [ENTRIES];
		bit [TYPE_W-1:0]   type_of [ENTRIES];
		bit [ADDR_W-1:0]   hi_of [ENTRIES];
		bit [ADDR_W-1:0]   lo_of [ENTRIES];
		bit [TIME_W-1:0]   expiry_of [ENTRIES];
		rsp_t              rsp_due [$];
		int                mismatches;
		bit                have_victim;
		bit [KEY_W-1:0]    victim_key;
		bit [TYPE_W-1:0]   victim_type;

		function int pending();
			return rsp_due.size();
		endfunction

		function int live_count();
			int n;
			n = 0;
			for (int i = 0; i < ENTRIES; i++)
				n += used[i];
			return n;
		endfunction

		function int pick_live();
			int start;
			int idx;
			start = $urandom_range(ENTRIES - 1);
			for (int n = 0; n < ENTRIES; n++) begin
				idx = (start + n) % ENTRIES;
				if (used[idx])
					return idx;
			end
			return -1;
		endfunction

		// works out the response of one accepted request and updates the table
		function void apply_request(req_t r);
			rsp_t want;
			int slot;
			bit found;
			bit have_free;
			want = '0;
			case (op_t'(r.req_type))
			OP_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (used[i] && key_of[i] == r.lookup_key && type_of[i] == r.rec_type) begin
						if (r.now_ms >= expiry_of[i]) begin
							used[i] = 1'b0;
							want.expired_removed = 1'b1;
						end else begin
							want.hit = 1'b1;
							want.out_addr_hi = hi_of[i];
							want.out_addr_lo = lo_of[i];
						end
						break;
					end
				end
			end
			OP_STORE: begin
				if (r.ttl_sec != 0 && r.lookup_key != 0) begin
					slot = 0;
					found = 1'b0;
					have_free = 1'b0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (used[i] && key_of[i] == r.lookup_key && type_of[i] == r.rec_type) begin
							slot = i;
							found = 1'b1;
							break;
						end
						if (!used[i] && !have_free) begin
							slot = i;
							have_free = 1'b1;
						end
					end
					// full table: lowest index among the earliest expiries
					if (!found && !have_free) begin
						slot = 0;
						for (int i = 1; i < ENTRIES; i++)
							if (expiry_of[i] < expiry_of[slot])
								slot = i;
						have_victim = 1'b1;
						victim_key = key_of[slot];
						victim_type = type_of[slot];
					end
					used[slot] = 1'b1;
					key_of[slot] = r.lookup_key;
					type_of[slot] = r.rec_type;
					hi_of[slot] = r.addr_hi;
					lo_of[slot] = r.addr_lo;
					expiry_of[slot] = r.now_ms + 64'(r.ttl_sec) * MSEC_PER_SEC;
				end
			end
			OP_SWEEP: begin
				for (int i = 0; i < ENTRIES; i++)
					if (used[i] && r.now_ms >= expiry_of[i])
						used[i] = 1'b0;
			end
			default: ;
			endcase
			rsp_due.push_back(want);
		endfunction

		function void report_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (rsp_due.size() == 0) begin
				$display("%0t: response with none expected, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = rsp_due.pop_front();
			report_field("hit", 64'(want.hit), 64'(got.hit));
			report_field("expired_removed", 64'(want.expired_removed), 64'(got.expired_removed));
			report_field("out_addr_hi", want.out_addr_hi, got.out_addr_hi);
			report_field("out_addr_lo", want.out_addr_lo, got.out_addr_lo);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	cache_mirror_t mirror = new();
	int sent_count = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	bit rsp_holdoff = 1'b0;
	logic [TIME_W-1:0] clock_ms;

	ttl_record_cache dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always #5 clk = ~clk;

	function automatic req_t make_req(input op_t op, input logic [KEY_W-1:0] key,
			input logic [TYPE_W-1:0] rtype, input logic [ADDR_W-1:0] hi,
			input logic [ADDR_W-1:0] lo, input logic [TTL_W-1:0] ttl,
			input logic [TIME_W-1:0] now);
		req_t r;
		r.req_type = op;
		r.lookup_key = key;
		r.rec_type = rtype;
		r.addr_hi = hi;
		r.addr_lo = lo;
		r.ttl_sec = ttl;
		r.now_ms = now;
		return r;
	endfunction

	function automatic req_t random_fields();
		return make_req(op_t'($urandom_range(3)), {$urandom, $urandom}, 16'($urandom),
			{$urandom, $urandom}, {$urandom, $urandom}, $urandom, {$urandom, $urandom});
	endfunction

	function automatic logic [TTL_W-1:0] pick_ttl();
		logic [TTL_W-1:0] ttl;
		ttl = ($urandom_range(3) == 0) ? 32'($urandom_range(1, 4)) : 32'($urandom);
		return (ttl == 0) ? 32'd1 : ttl;
	endfunction

	task automatic wait_for_results();
		while (mirror.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_request(input req_t r);
		if (sent_count == PAUSE_AT) begin
			@(negedge clk);
			req_valid <= 1'b0;
			wait_for_results();
		end
		if (sent_count == HOLDOFF_AT)
			rsp_holdoff = 1'b1;
		case ((sent_count / PHASE_LEN) % 4)
		0: begin
			send_idle_pct = 0;
			rsp_stall_pct = 0;
		end
		1: begin
			send_idle_pct = 88;
			rsp_stall_pct = 0;
		end
		2: begin
			send_idle_pct = 0;
			rsp_stall_pct = 88;
		end
		default: begin
			send_idle_pct = 6;
			rsp_stall_pct = 6;
		end
		endcase
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		mirror.apply_request(r);
		sent_count++;
	endtask

	task automatic random_step(input step_mix_t mix);
		req_t r;
		int roll;
		int slot;
		int cut [5];
		case (mix)
		MIX_FILL: cut = '{95, 96, 98, 99, 99};
		MIX_EVICT: cut = '{50, 50, 50, 100, 100};
		default: cut = '{30, 40, 65, 75, 85};
		endcase
		roll = $urandom_range(99);
		if ($urandom_range(2) != 0)
			clock_ms += 64'($urandom_range(1, 3000));
		slot = mirror.pick_live();
		r = random_fields();
		if (roll < cut[0]) begin
			r.req_type = OP_STORE;
			if (r.lookup_key == 0)
				r.lookup_key = 64'd1;
			if ($urandom_range(9) < 7)
				r.rec_type = $urandom_range(1) ? 16'd1 : 16'd28;
			if ($urandom_range(1)) begin
				r.addr_hi = {$urandom, 32'h0};
				r.addr_lo = '0;
			end
			r.ttl_sec = pick_ttl();
			r.now_ms = clock_ms;
		end else if (roll < cut[1] && slot >= 0) begin
			r = make_req(OP_STORE, mirror.key_of[slot], mirror.type_of[slot], r.addr_hi,
				r.addr_lo, pick_ttl(), clock_ms);
		end else if (roll < cut[2] && slot >= 0) begin
			r = make_req(OP_LOOKUP, mirror.key_of[slot], mirror.type_of[slot], r.addr_hi,
				r.addr_lo, r.ttl_sec, clock_ms);
		end else if (roll < cut[3]) begin
			r.req_type = OP_LOOKUP;
			r.now_ms = clock_ms;
			if (mirror.have_victim) begin
				r.lookup_key = mirror.victim_key;
				r.rec_type = mirror.victim_type;
			end
		end else if (roll < cut[4]) begin
			r.req_type = OP_SWEEP;
			r.now_ms = clock_ms;
		end else if (mix != MIX_FREE && r.req_type == OP_SWEEP) begin
			// a sweep at a random time would empty the table while filling it
			r.req_type = OP_NONE;
		end
		send_request(r);
	endtask

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_holdoff) begin
				rsp_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				rsp_holdoff = 1'b0;
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			mirror.check_response(rsp);
	end

	initial begin
		logic [TIME_W-1:0] t0;
		logic [KEY_W-1:0] k1;
		logic [KEY_W-1:0] k3;
		logic [KEY_W-1:0] k4;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		clock_ms = {2'b01, 30'($urandom), $urandom};
		t0 = clock_ms;
		k1 = {$urandom, $urandom} | 64'h1;
		k3 = {$urandom, $urandom} | 64'h2;
		k4 = {$urandom, $urandom} | 64'h4;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, ignored stores
		send_request(make_req(OP_LOOKUP, k1, 16'd1, '0, '0, '0, t0));
		send_request(make_req(OP_STORE, '0, 16'd1, 64'h1234_5678_0000_0000, '0, 32'd10, t0));
		send_request(make_req(OP_LOOKUP, '0, 16'd1, '0, '0, '0, t0));
		send_request(make_req(OP_STORE, k1, 16'd1, {32'hC0A8_0001, 32'h0}, '0, '0, t0));
		send_request(make_req(OP_LOOKUP, k1, 16'd1, '0, '0, '0, t0));
		// hit, second type under the same key, update of a match
		send_request(make_req(OP_STORE, k1, 16'd1, {32'hC0A8_0001, 32'h0}, '0, 32'd5, t0));
		send_request(make_req(OP_LOOKUP, k1, 16'd1, '0, '0, '0, t0 + 64'd4999));
		send_request(make_req(OP_STORE, k1, 16'd28, '1, '1, '1, t0));
		send_request(make_req(OP_LOOKUP, k1, 16'd28, '0, '0, '0, t0 + 64'd1));
		send_request(make_req(OP_STORE, k1, 16'd1, {32'h0A00_0002, 32'h0}, '0, 32'd100,
			t0 + 64'd1));
		send_request(make_req(OP_LOOKUP, k1, 16'd1, '0, '0, '0, t0 + 64'd5000));
		// lookup exactly at expiry removes, then misses
		send_request(make_req(OP_LOOKUP, k1, 16'd1, '0, '0, '0, t0 + 64'd100001));
		send_request(make_req(OP_LOOKUP, k1, 16'd1, '0, '0, '0, t0 + 64'd100001));
		// expiry wraps past the top of the time range
		send_request(make_req(OP_STORE, '1, '1, {$urandom, $urandom}, {$urandom, $urandom},
			'1, '1));
		send_request(make_req(OP_LOOKUP, '1, '1, '0, '0, '0, '0));
		send_request(make_req(OP_LOOKUP, '1, '1, '0, '0, '0, '1));
		// sweep clears only the expired ones
		send_request(make_req(OP_STORE, k3, 16'd1, {32'h0A00_0003, 32'h0}, '0, 32'd1, t0));
		send_request(make_req(OP_STORE, k4, 16'd1, {32'h0A00_0004, 32'h0}, '0, 32'd1000, t0));
		send_request(make_req(OP_SWEEP, '0, '0, '0, '0, '0, t0 + 64'd1000));
		send_request(make_req(OP_LOOKUP, k3, 16'd1, '0, '0, '0, t0 + 64'd1000));
		send_request(make_req(OP_LOOKUP, k4, 16'd1, '0, '0, '0, t0 + 64'd1000));
		send_request(make_req(OP_NONE, '1, '1, '1, '1, '1, '1));
		send_request(make_req(OP_SWEEP, '0, '0, '0, '0, '0, '0));
		clock_ms = t0 + 64'd2000;

		repeat (485) random_step(MIX_FILL);
		repeat (12) random_step(MIX_EVICT);
		repeat (50) random_step(MIX_FREE);

		@(negedge clk);
		req_valid <= 1'b0;
		wait_for_results();
		repeat (ENTRIES + 8) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending() == 0) begin
			$display("** ttl_record_cache: PASSED **");
		end else begin
			$display("** ttl_record_cache: FAILED **");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("** ttl_record_cache: FAILED **");
		$finish;
	end

endmodule
